// ----- rtl/imsu_pkg.sv -----
// Package for the Ising Metropolis spin update block: field widths, codes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package imsu_pkg;

    localparam int LATTICE_ROWS_DEF = 64;
    localparam int LATTICE_COLS_DEF = 64;

    localparam int SITE_W      = 6;
    localparam int RANDOM_W    = 32;
    localparam int THRESH_W    = 33;
    localparam int PRODUCT_W   = 4;
    localparam int BOND_SUM_W  = 15;
    localparam int CFG_INDEX_W = 4;
    localparam int COUNT_W     = 3;
    localparam int DELTA_W     = 5;

    // Item modes.
    localparam logic MODE_TRIAL = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_NEG4 = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_NEG2 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_POS2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_POS4 = CFG_INDEX_W'(3);

    // Number of neighbours that agree with the centre spin; the product is 2*count - 4.
    localparam logic [COUNT_W-1:0] AGREE_PROD_NEG4 = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] AGREE_PROD_NEG2 = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] AGREE_PROD_ZERO = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] AGREE_PROD_POS2 = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] AGREE_PROD_POS4 = COUNT_W'(4);

    localparam logic [PRODUCT_W-1:0] PRODUCT_BIAS = PRODUCT_W'(4);
    localparam logic [DELTA_W-1:0]   DELTA_BIAS   = DELTA_W'(8);

    // Probability one in the 2^32 scale: every random value lies below it.
    localparam logic [THRESH_W-1:0] THRESH_ONE  = 33'h1_0000_0000;
    localparam logic [THRESH_W-1:0] THRESH_ZERO = 33'h0_0000_0000;

    typedef logic [THRESH_W-1:0] thresh_t;

    typedef struct packed {
        thresh_t neg4;
        thresh_t neg2;
        thresh_t pos2;
        thresh_t pos4;
    } thresh_set_t;

    typedef struct packed {
        logic                        accepted;
        logic                        spin_after;
        logic signed [PRODUCT_W-1:0] local_product;
        logic signed [DELTA_W-1:0]   bond_delta;
    } trial_result_t;

endpackage

// ----- rtl/imsu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on imsu_pkg for its default sizes.
`timescale 1ns / 1ps

module imsu_ram #(
    parameter int WIDTH = imsu_pkg::LATTICE_COLS_DEF,
    parameter int DEPTH = imsu_pkg::LATTICE_ROWS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/imsu_cfg_regs.sv -----
// Acceptance threshold registers written through the configuration channel.
// Depends on imsu_pkg.
`timescale 1ns / 1ps

module imsu_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr,
    input  logic [imsu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imsu_pkg::THRESH_W-1:0]      cfg_data,
    output imsu_pkg::thresh_set_t              thresh
);

    imsu_pkg::thresh_set_t thresh_reg;
    imsu_pkg::thresh_set_t thresh_next;

    always_comb begin
        thresh_next = thresh_reg;
        if (cfg_wr) begin
            unique case (cfg_index)
                imsu_pkg::CFG_THRESH_NEG4: thresh_next.neg4 = cfg_data;
                imsu_pkg::CFG_THRESH_NEG2: thresh_next.neg2 = cfg_data;
                imsu_pkg::CFG_THRESH_POS2: thresh_next.pos2 = cfg_data;
                imsu_pkg::CFG_THRESH_POS4: thresh_next.pos4 = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.neg4 <= imsu_pkg::THRESH_ONE;
            thresh_reg.neg2 <= imsu_pkg::THRESH_ONE;
            thresh_reg.pos2 <= imsu_pkg::THRESH_ZERO;
            thresh_reg.pos4 <= imsu_pkg::THRESH_ZERO;
        end else begin
            thresh_reg <= thresh_next;
        end
    end

    assign thresh = thresh_reg;

endmodule

// ----- rtl/imsu_lattice.sv -----
// Spin lattice store: three identical row RAMs give the rows above, at and below a site
// together. Per-row valid bits stand in for the all-up reset. Depends on imsu_pkg, imsu_ram.
`timescale 1ns / 1ps

module imsu_lattice #(
    parameter int LATTICE_ROWS = imsu_pkg::LATTICE_ROWS_DEF,
    parameter int LATTICE_COLS = imsu_pkg::LATTICE_COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [$clog2(LATTICE_ROWS)-1:0] rd_row_up,
    input  logic [$clog2(LATTICE_ROWS)-1:0] rd_row_cur,
    input  logic [$clog2(LATTICE_ROWS)-1:0] rd_row_dn,
    input  logic                            wr_en,
    input  logic [$clog2(LATTICE_ROWS)-1:0] wr_row,
    input  logic [LATTICE_COLS-1:0]         wr_data,
    output logic [LATTICE_COLS-1:0]         row_up,
    output logic [LATTICE_COLS-1:0]         row_cur,
    output logic [LATTICE_COLS-1:0]         row_dn
);

    localparam int RW     = $clog2(LATTICE_ROWS);
    localparam int COPIES = 3;

    logic [RW-1:0]           rd_addr     [COPIES];
    logic [RW-1:0]           addr_reg    [COPIES];
    logic [LATTICE_COLS-1:0] ram_data    [COPIES];
    logic [LATTICE_COLS-1:0] row_data    [COPIES];

    logic [LATTICE_ROWS-1:0] row_valid_reg;
    logic [LATTICE_ROWS-1:0] row_valid_next;
    logic                    fwd_valid_reg;
    logic [RW-1:0]           fwd_row_reg;
    logic [LATTICE_COLS-1:0] fwd_data_reg;

    assign rd_addr[0] = rd_row_up;
    assign rd_addr[1] = rd_row_cur;
    assign rd_addr[2] = rd_row_dn;

    for (genvar g = 0; g < COPIES; g++) begin : g_copy
        imsu_ram #(
            .WIDTH (LATTICE_COLS),
            .DEPTH (LATTICE_ROWS)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (wr_row),
            .wr_data (wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_addr[g]),
            .rd_data (ram_data[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int i = 0; i < COPIES; i++) begin
                addr_reg[i] <= rd_addr[i];
            end
        end
        if (wr_en) begin
            fwd_row_reg  <= wr_row;
            fwd_data_reg <= wr_data;
        end
    end

    assign row_valid_next = row_valid_reg |
                            (wr_en ? (LATTICE_ROWS'(1) << wr_row) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            fwd_valid_reg <= fwd_valid_reg | wr_en;
        end
    end

    // A write on the edge that issued the read is not seen by the RAM output, so the
    // most recent written row is held aside and substituted on an address match.
    // Rows never written read as all spins up.
    always_comb begin
        for (int i = 0; i < COPIES; i++) begin
            if (fwd_valid_reg && (fwd_row_reg == addr_reg[i])) begin
                row_data[i] = fwd_data_reg;
            end else if (!row_valid_reg[addr_reg[i]]) begin
                row_data[i] = '1;
            end else begin
                row_data[i] = ram_data[i];
            end
        end
    end

    assign row_up  = row_data[0];
    assign row_cur = row_data[1];
    assign row_dn  = row_data[2];

endmodule

// ----- rtl/imsu_decide.sv -----
// Metropolis decision for one site: neighbour agreement count, threshold select and
// compare, flip and bond sum change. Purely combinational; depends on imsu_pkg.
`timescale 1ns / 1ps

module imsu_decide #(
    parameter int LATTICE_COLS = imsu_pkg::LATTICE_COLS_DEF
) (
    input  logic                              mode,
    input  logic [$clog2(LATTICE_COLS)-1:0]   col,
    input  logic [LATTICE_COLS-1:0]           row_up,
    input  logic [LATTICE_COLS-1:0]           row_cur,
    input  logic [LATTICE_COLS-1:0]           row_dn,
    input  logic [imsu_pkg::RANDOM_W-1:0]     random_value,
    input  imsu_pkg::thresh_set_t             thresh,
    output imsu_pkg::trial_result_t           result
);

    localparam int CW = $clog2(LATTICE_COLS);

    logic [CW-1:0]                     col_left;
    logic [CW-1:0]                     col_right;
    logic                              spin;
    logic [imsu_pkg::COUNT_W-1:0]      agree;
    imsu_pkg::thresh_t                 thresh_sel;
    logic                              pass;
    logic                              trial;
    logic                              flip;

    assign col_left  = (col == '0) ? CW'(LATTICE_COLS - 1) : col - CW'(1);
    assign col_right = (col == CW'(LATTICE_COLS - 1)) ? '0 : col + CW'(1);

    assign spin  = row_cur[col];
    assign agree = {2'b00, spin ~^ row_up[col]}
                 + {2'b00, spin ~^ row_dn[col]}
                 + {2'b00, spin ~^ row_cur[col_left]}
                 + {2'b00, spin ~^ row_cur[col_right]};

    always_comb begin
        case (agree)
            imsu_pkg::AGREE_PROD_NEG4: thresh_sel = thresh.neg4;
            imsu_pkg::AGREE_PROD_NEG2: thresh_sel = thresh.neg2;
            imsu_pkg::AGREE_PROD_ZERO: thresh_sel = imsu_pkg::THRESH_ONE;
            imsu_pkg::AGREE_PROD_POS2: thresh_sel = thresh.pos2;
            imsu_pkg::AGREE_PROD_POS4: thresh_sel = thresh.pos4;
            default:                   thresh_sel = imsu_pkg::THRESH_ONE;
        endcase
    end

    assign pass  = {1'b0, random_value} < thresh_sel;
    assign trial = (mode == imsu_pkg::MODE_TRIAL);
    assign flip  = trial && pass;

    always_comb begin
        result.accepted      = flip;
        result.spin_after    = spin ^ flip;
        result.local_product = trial ? $signed({agree, 1'b0} - imsu_pkg::PRODUCT_BIAS) : '0;
        // A flip changes the bond sum by -2p = 8 - 4*count.
        result.bond_delta    = flip ? $signed(imsu_pkg::DELTA_BIAS - {agree, 2'b00}) : '0;
    end

endmodule

// ----- rtl/ising_metropolis_spin_update.sv -----
// Top level of the Metropolis spin update block for a periodic 2D Ising lattice.
// Depends on imsu_pkg, imsu_cfg_regs, imsu_lattice, imsu_decide.
//
//  Channel   Direction  Transfer when           Payload
//  s_        in         s_valid & s_ready       mode, site_row, site_col, random_value
//  m_        out        m_valid & m_ready       spin_after, accepted, local_product, bond_sum
//  cfg_      in         cfg_valid & cfg_ready   cfg_index, cfg_data (threshold registers)
//
// One item is taken per cycle while the result register is not stalled; the row RAM
// read register loads at the transfer edge itself and the result register when the item
// advances. The three row RAM read ports set the rate. Reset clears the per-row valid
// bits, so the lattice reads all up immediately; no clearing pass is needed. A stalled
// result register holds the item behind it and s_ready falls; cfg_ready is always high.
`timescale 1ns / 1ps

module ising_metropolis_spin_update #(
    parameter int LATTICE_ROWS = imsu_pkg::LATTICE_ROWS_DEF,
    parameter int LATTICE_COLS = imsu_pkg::LATTICE_COLS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_mode,
    input  logic [imsu_pkg::SITE_W-1:0]            s_site_row,
    input  logic [imsu_pkg::SITE_W-1:0]            s_site_col,
    input  logic [imsu_pkg::RANDOM_W-1:0]          s_random_value,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_spin_after,
    output logic                                   m_accepted,
    output logic signed [imsu_pkg::PRODUCT_W-1:0]  m_local_product,
    output logic signed [imsu_pkg::BOND_SUM_W-1:0] m_bond_sum,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [imsu_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [imsu_pkg::THRESH_W-1:0]          cfg_data
);

    localparam int RW         = $clog2(LATTICE_ROWS);
    localparam int CW         = $clog2(LATTICE_COLS);
    localparam int SITES      = LATTICE_ROWS * LATTICE_COLS;
    localparam int WRAP_DEPTH = 2 ** imsu_pkg::SITE_W;
    localparam int BOND_W_MIN = $clog2(2 * SITES + 1) + 1;
    localparam int BOND_W     = (BOND_W_MIN > imsu_pkg::BOND_SUM_W) ? BOND_W_MIN
                                                                    : imsu_pkg::BOND_SUM_W;
    localparam logic [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SITES);

    // Coordinate wrap tables, filled at elaboration.
    logic [RW-1:0] row_wrap [WRAP_DEPTH];
    logic [CW-1:0] col_wrap [WRAP_DEPTH];

    for (genvar i = 0; i < WRAP_DEPTH; i++) begin : g_wrap
        assign row_wrap[i] = RW'(i % LATTICE_ROWS);
        assign col_wrap[i] = CW'(i % LATTICE_COLS);
    end

    logic                    in_xfer;
    logic [RW-1:0]           in_row;
    logic [RW-1:0]           in_row_up;
    logic [RW-1:0]           in_row_dn;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_mode_reg;
    logic [RW-1:0]           s1_row_reg;
    logic [CW-1:0]           s1_col_reg;
    logic [imsu_pkg::RANDOM_W-1:0] s1_random_reg;
    logic                    s1_adv;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_spin_after_reg;
    logic                    m_accepted_reg;
    logic signed [imsu_pkg::PRODUCT_W-1:0]  m_local_product_reg;
    logic signed [imsu_pkg::BOND_SUM_W-1:0] m_bond_sum_reg;

    logic [BOND_W-1:0]       bond_reg;
    logic [BOND_W-1:0]       bond_next;

    logic [LATTICE_COLS-1:0] row_up;
    logic [LATTICE_COLS-1:0] row_cur;
    logic [LATTICE_COLS-1:0] row_dn;
    logic [LATTICE_COLS-1:0] new_row;
    logic                    lattice_wr;

    imsu_pkg::thresh_set_t   thresh;
    imsu_pkg::trial_result_t result;

    assign cfg_ready = 1'b1;

    imsu_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thresh    (thresh)
    );

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign in_xfer = s_valid && s_ready;

    assign in_row    = row_wrap[s_site_row];
    assign in_row_up = (in_row == '0) ? RW'(LATTICE_ROWS - 1) : in_row - RW'(1);
    assign in_row_dn = (in_row == RW'(LATTICE_ROWS - 1)) ? '0 : in_row + RW'(1);

    imsu_lattice #(
        .LATTICE_ROWS (LATTICE_ROWS),
        .LATTICE_COLS (LATTICE_COLS)
    ) u_lattice (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (in_xfer),
        .rd_row_up  (in_row_up),
        .rd_row_cur (in_row),
        .rd_row_dn  (in_row_dn),
        .wr_en      (lattice_wr),
        .wr_row     (s1_row_reg),
        .wr_data    (new_row),
        .row_up     (row_up),
        .row_cur    (row_cur),
        .row_dn     (row_dn)
    );

    imsu_decide #(
        .LATTICE_COLS (LATTICE_COLS)
    ) u_decide (
        .mode         (s1_mode_reg),
        .col          (s1_col_reg),
        .row_up       (row_up),
        .row_cur      (row_cur),
        .row_dn       (row_dn),
        .random_value (s1_random_reg),
        .thresh       (thresh),
        .result       (result)
    );

    assign new_row    = row_cur ^ (LATTICE_COLS'(result.accepted) << s1_col_reg);
    assign lattice_wr = s1_adv && result.accepted;
    assign bond_next  = bond_reg
                      + {{(BOND_W - imsu_pkg::DELTA_W){result.bond_delta[imsu_pkg::DELTA_W-1]}},
                         result.bond_delta};

    assign s1_valid_next = in_xfer || (s1_valid_reg && !s1_adv);
    assign m_valid_next  = s1_adv || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            bond_reg     <= BOND_RESET;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s1_adv) begin
                bond_reg <= bond_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_mode_reg   <= s_mode;
            s1_row_reg    <= in_row;
            s1_col_reg    <= col_wrap[s_site_col];
            s1_random_reg <= s_random_value;
        end
        if (s1_adv) begin
            m_spin_after_reg    <= result.spin_after;
            m_accepted_reg      <= result.accepted;
            m_local_product_reg <= result.local_product;
            m_bond_sum_reg      <= $signed(bond_next[imsu_pkg::BOND_SUM_W-1:0]);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_spin_after    = m_spin_after_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_local_product = m_local_product_reg;
    assign m_bond_sum      = m_bond_sum_reg;

endmodule
